>>> rtl/signed_decimal_to_seven_segment_core_defines.svh
// assertion macros shared by the signed decimal to seven-segment core
// depends on nothing; modules that use these must have clk and arst_n in scope
`ifndef SIGNED_DECIMAL_TO_SEVEN_SEGMENT_CORE_DEFINES_SVH
`define SIGNED_DECIMAL_TO_SEVEN_SEGMENT_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define SD7SEG_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sd7seg assertion failed");

`define SD7SEG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sd7seg assertion failed");

`else

`define SD7SEG_ASSERT_NOW(label, ante, cons)
`define SD7SEG_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> rtl/sd7seg_pkg.sv
// types, constants and the digit font of the signed decimal to seven-segment core
// used by the controller, the datapath and the top level

package sd7seg_pkg;

	localparam int unsigned VALUE_W = 16;
	localparam int unsigned MAG_W = 14;
	localparam int unsigned DIGITS = 4;
	localparam int unsigned SEG_W = 8;
	localparam int unsigned CNT_W = 4;
	localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(MAG_W - 1);

	localparam logic signed [VALUE_W-1:0] POS_LIMIT = 16'sd9999;
	localparam logic signed [VALUE_W-1:0] NEG_LIMIT = -16'sd999;

	localparam logic [1:0] RANGE_OK = 2'd0;
	localparam logic [1:0] RANGE_OVER = 2'd1;
	localparam logic [1:0] RANGE_UNDER = 2'd2;

	localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;
	localparam logic [SEG_W-1:0] SEG_MINUS = 8'h10;
	localparam logic [SEG_W-1:0] SEG_OVER3 = 8'h1B;
	localparam logic [SEG_W-1:0] SEG_UNDER3 = 8'h6B;
	localparam logic [SEG_W-1:0] SEG_ERR2 = 8'hD1;
	localparam logic [SEG_W-1:0] SEG_ERR1 = 8'h43;
	localparam logic [SEG_W-1:0] SEG_ERR0 = 8'h1B;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic write;
	} cmd_t;

	function automatic logic [SEG_W-1:0] font(input logic [3:0] digit);
		logic [SEG_W-1:0] seg;
		unique case (digit)
			4'd0: seg = 8'hEB;
			4'd1: seg = 8'h28;
			4'd2: seg = 8'hB3;
			4'd3: seg = 8'hBA;
			4'd4: seg = 8'h78;
			4'd5: seg = 8'hDA;
			4'd6: seg = 8'hDB;
			4'd7: seg = 8'hA8;
			4'd8: seg = 8'hFB;
			4'd9: seg = 8'hFA;
			default: seg = SEG_BLANK;
		endcase
		return seg;
	endfunction

endpackage

>>> rtl/signed_decimal_to_seven_segment_core.sv
// top level of the signed decimal to seven-segment core
// depends on sd7seg_pkg, sd7seg_ctrl and sd7seg_dp

// Converts one signed 16-bit value into four seven-segment patterns, rightmost
// place on digit0_segments. Values above 9999 and below -999 give fixed overflow
// and underflow words, flagged on range_status. One value is converted at a time:
// a transfer in is followed by 14 shift-add steps of the bcd converter and by
// the write of the encoded patterns; a new value is taken only after the write.
// The result sits in an output register, so the next value is taken while the
// previous result still waits; a stalled output holds the converter in its
// write state only once a second result is ready.

module signed_decimal_to_seven_segment_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [sd7seg_pkg::VALUE_W-1:0] value,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [sd7seg_pkg::SEG_W-1:0]          digit0_segments,
	output logic [sd7seg_pkg::SEG_W-1:0]          digit1_segments,
	output logic [sd7seg_pkg::SEG_W-1:0]          digit2_segments,
	output logic [sd7seg_pkg::SEG_W-1:0]          digit3_segments,
	output logic [1:0]                            range_status
);

	sd7seg_pkg::cmd_t cmd;

	sd7seg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	sd7seg_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.value           (value),
		.digit0_segments (digit0_segments),
		.digit1_segments (digit1_segments),
		.digit2_segments (digit2_segments),
		.digit3_segments (digit3_segments),
		.range_status    (range_status)
	);

endmodule

>>> rtl/sd7seg_ctrl.sv
// controller of the seven-segment core: sequences load, shift-add steps and output write
// depends on sd7seg_pkg and signed_decimal_to_seven_segment_core_defines.svh

`include "signed_decimal_to_seven_segment_core_defines.svh"

module sd7seg_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	output sd7seg_pkg::cmd_t     cmd
);

	sd7seg_pkg::state_t state_q, state_d;
	logic [sd7seg_pkg::CNT_W-1:0] cnt_q;
	logic out_valid_q;
	logic out_free;
	logic in_xfer;

	assign out_free = !out_valid_q || !out_stall;
	assign in_xfer = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sd7seg_pkg::ST_IDLE: begin
				if (in_valid)
					state_d = sd7seg_pkg::ST_CONVERT;
			end
			sd7seg_pkg::ST_CONVERT: begin
				if (cnt_q == sd7seg_pkg::STEP_LAST)
					state_d = sd7seg_pkg::ST_WRITE;
			end
			sd7seg_pkg::ST_WRITE: begin
				if (out_free)
					state_d = sd7seg_pkg::ST_IDLE;
			end
			default: state_d = sd7seg_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		cmd = '0;
		unique case (state_q)
			sd7seg_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			sd7seg_pkg::ST_CONVERT: begin
				cmd.step = 1'b1;
			end
			sd7seg_pkg::ST_WRITE: begin
				cmd.write = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sd7seg_pkg::ST_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.step)
				cnt_q <= cnt_q + 1'b1;
			else
				cnt_q <= '0;
			if (cmd.write)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`SD7SEG_ASSERT_NEXT(a_accept_starts, in_xfer, state_q == sd7seg_pkg::ST_CONVERT && cnt_q == '0)
	`SD7SEG_ASSERT_NOW(a_write_free, cmd.write, !out_valid_q || !out_stall)
	`SD7SEG_ASSERT_NEXT(a_last_step, cmd.step && cnt_q == sd7seg_pkg::STEP_LAST, state_q == sd7seg_pkg::ST_WRITE)
	`SD7SEG_ASSERT_NEXT(a_write_shows, cmd.write, out_valid_q)

endmodule

>>> rtl/sd7seg_dp.sv
// datapath of the seven-segment core: range check, shift-add bcd conversion, encoding
// depends on sd7seg_pkg

module sd7seg_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sd7seg_pkg::cmd_t                   cmd,
	input  logic signed [sd7seg_pkg::VALUE_W-1:0] value,
	output logic [sd7seg_pkg::SEG_W-1:0]       digit0_segments,
	output logic [sd7seg_pkg::SEG_W-1:0]       digit1_segments,
	output logic [sd7seg_pkg::SEG_W-1:0]       digit2_segments,
	output logic [sd7seg_pkg::SEG_W-1:0]       digit3_segments,
	output logic [1:0]                         range_status
);

	logic [sd7seg_pkg::MAG_W-1:0] bin_q;
	logic [4*sd7seg_pkg::DIGITS-1:0] bcd_q;
	logic [1:0] range_q;
	logic neg_q;
	logic [sd7seg_pkg::SEG_W-1:0] seg_q [sd7seg_pkg::DIGITS];
	logic [1:0] range_out_q;

	logic [sd7seg_pkg::VALUE_W-1:0] mag;
	logic [4*sd7seg_pkg::DIGITS-1:0] bcd_adj;
	logic [1:0] top;
	logic [sd7seg_pkg::SEG_W-1:0] seg_d [sd7seg_pkg::DIGITS];

	assign mag = value[sd7seg_pkg::VALUE_W-1] ? (~value + 1'b1) : value;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < sd7seg_pkg::DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5)
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			else
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= mag[sd7seg_pkg::MAG_W-1:0];
			bcd_q <= '0;
			neg_q <= value[sd7seg_pkg::VALUE_W-1];
			if (value > sd7seg_pkg::POS_LIMIT)
				range_q <= sd7seg_pkg::RANGE_OVER;
			else if (value < sd7seg_pkg::NEG_LIMIT)
				range_q <= sd7seg_pkg::RANGE_UNDER;
			else
				range_q <= sd7seg_pkg::RANGE_OK;
		end else if (cmd.step) begin
			bcd_q <= {bcd_adj[4*sd7seg_pkg::DIGITS-2:0], bin_q[sd7seg_pkg::MAG_W-1]};
			bin_q <= {bin_q[sd7seg_pkg::MAG_W-2:0], 1'b0};
		end
	end

	// highest nonzero digit place, zero shows a single digit
	always_comb begin
		if (bcd_q[15:12] != 4'd0)
			top = 2'd3;
		else if (bcd_q[11:8] != 4'd0)
			top = 2'd2;
		else if (bcd_q[7:4] != 4'd0)
			top = 2'd1;
		else
			top = 2'd0;
	end

	always_comb begin
		for (int i = 0; i < sd7seg_pkg::DIGITS; i++) begin
			if (3'(i) <= {1'b0, top})
				seg_d[i] = sd7seg_pkg::font(bcd_q[4*i +: 4]);
			else if (neg_q && 3'(i) == {1'b0, top} + 3'd1)
				seg_d[i] = sd7seg_pkg::SEG_MINUS;
			else
				seg_d[i] = sd7seg_pkg::SEG_BLANK;
		end
		case (range_q)
			sd7seg_pkg::RANGE_OVER: begin
				seg_d[3] = sd7seg_pkg::SEG_OVER3;
				seg_d[2] = sd7seg_pkg::SEG_ERR2;
				seg_d[1] = sd7seg_pkg::SEG_ERR1;
				seg_d[0] = sd7seg_pkg::SEG_ERR0;
			end
			sd7seg_pkg::RANGE_UNDER: begin
				seg_d[3] = sd7seg_pkg::SEG_UNDER3;
				seg_d[2] = sd7seg_pkg::SEG_ERR2;
				seg_d[1] = sd7seg_pkg::SEG_ERR1;
				seg_d[0] = sd7seg_pkg::SEG_ERR0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_out_q <= sd7seg_pkg::RANGE_OK;
		end else if (cmd.write) begin
			range_out_q <= range_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			for (int i = 0; i < sd7seg_pkg::DIGITS; i++)
				seg_q[i] <= seg_d[i];
		end
	end

	assign digit0_segments = seg_q[0];
	assign digit1_segments = seg_q[1];
	assign digit2_segments = seg_q[2];
	assign digit3_segments = seg_q[3];
	assign range_status = range_out_q;

endmodule
